FILE: hdl/swcc_pkg.sv
// shared types, sizes and helpers of the sliding window co-occurrence counter
// no dependencies; imported by every module of the block but the checker
package swcc_pkg;

  localparam int VOCAB_WORDS = 256;
  localparam int MAX_WINDOW = 16;

  localparam int WORD_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int WIN_W      = 5;
  localparam int LIMIT_W    = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IDX_W      = (VOCAB_WORDS > 1) ? $clog2(VOCAB_WORDS) : 1;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_SENTENCE_LIMIT = CFG_ADDR_W'(1);

  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(5);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1000);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WORD_W-1:0]  word_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    OP_BUMP,
    OP_READ
  } op_kind_t;

  // one unit of work for the counter store
  typedef struct packed {
    op_kind_t kind;
    logic     zero;   // read outside the vocabulary returns zero
    addr_t    addr;
  } op_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_size;
    logic [LIMIT_W-1:0] sentence_limit;
  } cfg_t;

  function automatic logic in_vocab(word_t v);
    return int'(v) < VOCAB_WORDS;
  endfunction

  function automatic idx_t to_idx(word_t v);
    return idx_t'(v);
  endfunction

endpackage

FILE: hdl/swcc_queue.sv
// short op queue between the front part and the counter store
// depends on swcc_pkg
module swcc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  swcc_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output swcc_pkg::op_t pop_op,
  output logic          not_empty
);
  import swcc_pkg::*;

  op_t                slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_op    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: hdl/swcc_front.sv
// front part: accepts requests, keeps the sentence window, emits counter ops
// depends on swcc_pkg
module swcc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swcc_pkg::cfg_t          cfg,
  input  logic                    clr_busy,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_mode,
  input  swcc_pkg::word_t         in_word,
  input  swcc_pkg::word_t         in_row,
  input  swcc_pkg::word_t         in_col,
  output logic                    q_push,
  output swcc_pkg::op_t           q_op,
  input  logic                    q_full
);
  import swcc_pkg::*;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } fstate_t;

  fstate_t              state_r, state_nxt;
  word_t                recent_r [MAX_WINDOW];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [LIMIT_W-1:0]   pos_r, pos_nxt, pos_inc;
  word_t                cur_r, cur_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SLOT_W-1:0]    last_r, last_nxt;
  logic                 side_r, side_nxt;
  logic                 store;
  word_t                store_word;
  logic                 accept;
  int                   win_eff;
  int                   n_pair;
  word_t                old_word;

  assign in_tready = (state_r == F_IDLE) && !clr_busy && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign old_word  = recent_r[slot_r];
  assign pos_inc   = pos_r + 1'b1;

  // number of earlier words paired with the new one
  always_comb begin
    win_eff = (int'(cfg.window_size) > MAX_WINDOW) ? MAX_WINDOW : int'(cfg.window_size);
    n_pair  = (int'(fill_r) < win_eff) ? int'(fill_r) : win_eff;
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    slot_nxt   = slot_r;
    last_nxt   = last_r;
    side_nxt   = side_r;
    store      = 1'b0;
    store_word = cur_r;
    q_push     = 1'b0;
    q_op.kind  = OP_BUMP;
    q_op.zero  = 1'b0;
    q_op.addr  = {to_idx(cur_r), to_idx(old_word)};

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            q_push    = 1'b1;
            q_op.kind = OP_READ;
            q_op.zero = !(in_vocab(in_row) && in_vocab(in_col));
            q_op.addr = {to_idx(in_row), to_idx(in_col)};
          end else if (in_word == '0) begin
            fill_nxt = '0;
            pos_nxt  = '0;
          end else if (in_vocab(in_word)) begin
            if (n_pair == 0) begin
              store      = 1'b1;
              store_word = in_word;
            end else begin
              cur_nxt   = in_word;
              slot_nxt  = '0;
              side_nxt  = 1'b0;
              last_nxt  = SLOT_W'(n_pair - 1);
              state_nxt = F_EMIT;
            end
          end
        end
      end
      F_EMIT: begin
        if (!q_full) begin
          q_push    = 1'b1;
          q_op.addr = side_r ? {to_idx(old_word), to_idx(cur_r)}
                             : {to_idx(cur_r), to_idx(old_word)};
          if (!side_r) begin
            side_nxt = 1'b1;
          end else begin
            side_nxt = 1'b0;
            if (slot_r == last_r) begin
              store     = 1'b1;
              state_nxt = F_IDLE;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase

    // word stored: advance fill and position, end sentence at the limit
    if (store) begin
      if (pos_inc >= cfg.sentence_limit || pos_inc == '0) begin
        fill_nxt = '0;
        pos_nxt  = '0;
      end else begin
        fill_nxt = (fill_r < FILL_W'(MAX_WINDOW)) ? fill_r + 1'b1 : fill_r;
        pos_nxt  = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= '0;
      pos_r   <= '0;
      side_r  <= 1'b0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      side_r  <= side_nxt;
      slot_r  <= slot_nxt;
      cur_r   <= cur_nxt;
      last_r  <= last_nxt;
      if (store) begin
        for (int i = MAX_WINDOW - 1; i > 0; i--) begin
          recent_r[i] <= recent_r[i-1];
        end
        recent_r[0] <= store_word;
      end
    end
  end

endmodule

FILE: hdl/swcc_back.sv
// back part: counter store with clearing pass, read-modify-write pipe, result register
// depends on swcc_pkg
module swcc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  swcc_pkg::op_t            q_op,
  output logic                     q_pop,
  output logic                     clr_busy,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output swcc_pkg::count_t         out_count,
  output logic                     out_sat
);
  import swcc_pkg::*;

  count_t  mem [2**ADDR_W];
  count_t  rdata_r;

  logic    clr_busy_r;
  addr_t   clr_addr_r;

  logic    b_valid_r;
  op_t     b_op_r;
  logic    b_adv;

  logic    wb_valid_r;
  addr_t   wb_addr_r;
  count_t  wb_data_r;

  count_t  cur_val;
  count_t  bumped;
  logic    out_free;

  logic    mem_we;
  addr_t   mem_waddr;
  count_t  mem_wdata;

  logic    out_valid_r;
  count_t  out_count_r;
  logic    out_sat_r;

  assign clr_busy   = clr_busy_r;
  assign out_tvalid = out_valid_r;
  assign out_count  = out_count_r;
  assign out_sat    = out_sat_r;

  assign out_free = !out_valid_r || out_tready;
  assign b_adv    = b_valid_r && (b_op_r.kind == OP_BUMP || out_free);
  assign q_pop    = q_valid && !clr_busy_r && (!b_valid_r || b_adv);

  // the read was taken at the edge of the previous write: forward it
  assign cur_val = (wb_valid_r && wb_addr_r == b_op_r.addr) ? wb_data_r : rdata_r;
  assign bumped  = (cur_val == COUNT_MAX) ? cur_val : cur_val + 1'b1;

  always_comb begin
    mem_we    = clr_busy_r || (b_adv && b_op_r.kind == OP_BUMP);
    mem_waddr = clr_busy_r ? clr_addr_r : b_op_r.addr;
    mem_wdata = clr_busy_r ? '0 : bumped;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rdata_r <= mem[q_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_valid_r   <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (q_pop) begin
        b_valid_r <= 1'b1;
        b_op_r    <= q_op;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv && b_op_r.kind == OP_BUMP) begin
        wb_valid_r <= 1'b1;
        wb_addr_r  <= b_op_r.addr;
        wb_data_r  <= bumped;
      end
      if (b_adv && b_op_r.kind == OP_READ) begin
        out_valid_r <= 1'b1;
        out_count_r <= b_op_r.zero ? '0 : cur_val;
        out_sat_r   <= !b_op_r.zero && (cur_val == COUNT_MAX);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/sliding_window_cooccurrence_counter.sv
// sliding window co-occurrence counter, top level
// a push with no earlier neighbours makes no op, else it splits into 2n pair bumps for
// n pairs (n = min(window, fill)), one op per cycle while the queue is not full
// a read passes through the queue, the store read register and the result register
// synchronous active-low reset; afterwards a clearing pass zeroes all 65536 entries of
// the counter store, during which in_tready stays low (config writes still taken)
// depends on swcc_pkg, swcc_queue, swcc_front, swcc_back
module sliding_window_cooccurrence_counter (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // word[7:0], row[15:8], col[23:16]
  input  logic                                in_tuser,   // mode
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // count[31:0]
  output logic                                out_tuser,  // saturated
  // configuration writes
  input  logic                                cfg_we,
  input  logic [swcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [swcc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import swcc_pkg::*;

  // configuration registers, both back at their defaults after reset
  logic [WIN_W-1:0]   window_size_r;
  logic [LIMIT_W-1:0] sentence_limit_r;
  cfg_t               cfg;

  // front to back queue
  logic   q_push;
  op_t    q_in_op;
  logic   q_full;
  logic   q_pop;
  op_t    q_out_op;
  logic   q_valid;

  logic   clr_busy;
  count_t out_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r    <= WINDOW_RESET;
      sentence_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WINDOW_SIZE:    window_size_r    <= cfg_wdata[WIN_W-1:0];
        CFG_SENTENCE_LIMIT: sentence_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.window_size    = window_size_r;
  assign cfg.sentence_limit = sentence_limit_r;

  // front: takes requests, tracks the sentence, splits a push into pair bumps
  swcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr_busy  (clr_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_word   (in_tdata[7:0]),
    .in_row    (in_tdata[15:8]),
    .in_col    (in_tdata[23:16]),
    .q_push    (q_push),
    .q_op      (q_in_op),
    .q_full    (q_full)
  );

  // lets the front run ahead while the store or the result side stalls
  swcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_op    (q_out_op),
    .not_empty (q_valid)
  );

  // back: counter store, saturating bump and read results
  swcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_out_op),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_count  (out_count),
    .out_sat    (out_tuser)
  );

  assign out_tdata = out_count;

endmodule

FILE: hdl/swcc_checker.sv
// port-level checks for the co-occurrence counter, bound to the top level
// depends on sliding_window_cooccurrence_counter
module swcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // the clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken before counter store was cleared");

  // saturated flag matches the counter value
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata == 32'hFFFF_FFFF)))
    else $error("saturated flag disagrees with count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind sliding_window_cooccurrence_counter swcc_checker u_swcc_checker (.*);

FILE: sim/swcc_checker.sv
// scoreboard for the sliding window co-occurrence counter: predicts read results
// from the observed request and config traffic and compares them with the result channel
// depends on swcc_pkg
`timescale 1ns / 100ps

module swcc_scoreboard
  import swcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,   // word[7:0], row[15:8], col[23:16]
  input  logic                  in_tuser,   // mode
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,  // count[31:0]
  input  logic                  out_tuser,  // saturated
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    count_t count;
    logic   saturated;
  } read_result_t;

  read_result_t expected_reads[$];

  // shadow copy of the block state
  count_t             pair_counts [VOCAB_WORDS * VOCAB_WORDS];
  word_t              recent_words [MAX_WINDOW];
  int unsigned        recent_fill;
  logic [LIMIT_W-1:0] sent_pos;
  logic [WIN_W-1:0]   window_size;
  logic [LIMIT_W-1:0] sentence_limit;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int unsigned pair_index(word_t centre, word_t ctx_word);
    return int'(centre) * VOCAB_WORDS + int'(ctx_word);
  endfunction

  function automatic void bump_pair(word_t centre, word_t ctx_word);
    int unsigned a;
    a = pair_index(centre, ctx_word);
    if (pair_counts[a] != COUNT_MAX) pair_counts[a] = pair_counts[a] + 1;
  endfunction

  function automatic void push_word(word_t w);
    int unsigned span;
    int unsigned pairs;
    if (w == '0) begin
      recent_fill = 0;
      sent_pos = '0;
      return;
    end
    if (int'(w) >= VOCAB_WORDS) return;
    span = (int'(window_size) > MAX_WINDOW) ? MAX_WINDOW : int'(window_size);
    pairs = (recent_fill < span) ? recent_fill : span;
    // symmetric pairing: both orders, a repeated word hits one counter twice
    for (int i = 0; i < pairs; i++) begin
      bump_pair(w, recent_words[i]);
      bump_pair(recent_words[i], w);
    end
    for (int i = MAX_WINDOW - 1; i > 0; i--) recent_words[i] = recent_words[i-1];
    recent_words[0] = w;
    if (recent_fill < MAX_WINDOW) recent_fill++;
    sent_pos = sent_pos + 1'b1;
    // a limit of zero ends every sentence after one word
    if (sent_pos >= sentence_limit || sent_pos == '0) begin
      recent_fill = 0;
      sent_pos = '0;
    end
  endfunction

  function automatic read_result_t read_pair(word_t row, word_t col);
    read_result_t r;
    r.count = '0;
    if (int'(row) < VOCAB_WORDS && int'(col) < VOCAB_WORDS) r.count = pair_counts[pair_index(row, col)];
    r.saturated = (r.count == COUNT_MAX);
    return r;
  endfunction

  always @(posedge clk) begin
    read_result_t want;
    if (!rst_n) begin
      window_size = WINDOW_RESET;
      sentence_limit = LIMIT_RESET;
      recent_fill = 0;
      sent_pos = '0;
      foreach (pair_counts[a]) pair_counts[a] = '0;
      expected_reads.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_WINDOW_SIZE) window_size = cfg_wdata[WIN_W-1:0];
        else if (cfg_addr == CFG_SENTENCE_LIMIT) sentence_limit = cfg_wdata[LIMIT_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        if (op_kind_t'(in_tuser) == OP_READ)
          expected_reads.push_back(read_pair(in_tdata[15:8], in_tdata[23:16]));
        else
          push_word(in_tdata[7:0]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_reads.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with none expected: count %h saturated %b",
                     $realtime, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_reads.pop_front();
          if (want.count != out_tdata || want.saturated != out_tuser) begin
            if (fail_count < 10)
              $display("%0t: read mismatch: count exp %h got %h, saturated exp %b got %b",
                       $realtime, want.count, out_tdata, want.saturated, out_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = expected_reads.size();
  end

endmodule

FILE: sim/sliding_window_cooccurrence_counter_tb.sv
// regression bench for the sliding window co-occurrence counter: directed and random
// push/read traffic under several config settings and handshake stall patterns
// depends on swcc_pkg, swcc_scoreboard and the block itself
`timescale 1ns / 100ps

module sliding_window_cooccurrence_counter_tb;
  import swcc_pkg::*;

  // longest stretch with no handshake we tolerate; covers the counter store clear
  // after reset several times over
  localparam int QUIET_LIMIT = 200000;
  // a push makes no result but can keep the store busy with up to 2*MAX_WINDOW pair bumps
  localparam int SETTLE_CYCLES = 2 * MAX_WINDOW + 8;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_REQUESTS = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int quiet_cycles = 0;

  // percent of cycles the sender sits idle / the receiver holds off
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_cooccurrence_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  swcc_scoreboard scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sliding_window_cooccurrence_counter regression: fail");
      $finish;
    end
  end

  // one request; in_tuser carries the kind, a push maps onto OP_BUMP
  // idle cycles go out with junk on the data lines
  task automatic send_request(op_kind_t kind, word_t word, word_t row, word_t col);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 24'($urandom);
      in_tuser <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {col, row, word};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push(word_t word);
    send_request(OP_BUMP, word, word_t'($urandom), word_t'($urandom));
  endtask

  task automatic read(word_t row, word_t col);
    send_request(OP_READ, word_t'($urandom), row, col);
  endtask

  // stop sending, wait for every read result, then give the store time to
  // finish whatever bumps a trailing push started
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [WIN_W-1:0] window, logic [LIMIT_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_WINDOW_SIZE;
    cfg_wdata <= CFG_DATA_W'(window);
    @(posedge clk);
    cfg_addr <= CFG_SENTENCE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a handful of small indices so that counters build up and reads hit
  // them, sometimes a sentence end, sometimes anything in the vocabulary
  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 65) return word_t'($urandom_range(1, 6));
    return word_t'($urandom_range(1, 255));
  endfunction

  function automatic word_t pick_index();
    if ($urandom_range(99) < 70) return word_t'($urandom_range(0, 6));
    return word_t'($urandom_range(0, 255));
  endfunction

  task automatic send_random_request();
    if ($urandom_range(99) < 30) read(pick_index(), pick_index());
    else push(pick_word());
  endtask

  initial begin
    logic [WIN_W-1:0]   window;
    logic [LIMIT_W-1:0] limit;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset config (window 5, limit 1000)
    // the first request waits out the clear of the counter store
    push(8'd255);
    push(8'd1);
    push(8'd255);          // same word inside the window: one counter bumped twice
    read(8'd255, 8'd1);
    read(8'd1, 8'd255);
    read(8'd255, 8'd255);
    read(8'd0, 8'd0);      // the end marker is never counted
    read(8'd255, 8'd0);
    push(8'd0);            // end of sentence
    push(8'd2);
    read(8'd2, 8'd255);    // no pairing across a sentence end
    read(8'd1, 8'd1);
    for (int w = 3; w <= 9; w++) push(word_t'(w));
    read(8'd9, 8'd3);      // just outside the window
    read(8'd9, 8'd4);      // at the window edge
    read(8'd4, 8'd9);
    send_request(OP_READ, 8'd0, 8'd8, 8'd8);   // a read with word 0 ends nothing
    push(8'd10);
    read(8'd10, 8'd5);
    drain();

    // random part: each segment has its own config, phases of idling rotate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin window = 5'd16; limit = 16'd65535; end
        1: begin window = 5'd1;  limit = 16'd1000;  end
        2: begin window = 5'd31; limit = 16'd3;     end   // beyond the window depth
        3: begin window = 5'd0;  limit = 16'd0;     end   // pairs nothing, limit acts as 1
        4: begin window = 5'd5;  limit = 16'd1;     end
        5: begin window = 5'd17; limit = 16'd65535; end
        6: begin window = 5'd2;  limit = 16'd7;     end
        default: begin window = 5'd16; limit = 16'd2; end
      endcase
      write_config(window, limit);

      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase

      for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
        // mid-segment hold-off until every outstanding read has come back
        if (n == SEGMENT_REQUESTS / 2) drain();
        send_random_request();
      end
      drain();
    end

    stall_pct = 0;
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_window_cooccurrence_counter regression: pass");
    end else begin
      $display("sliding_window_cooccurrence_counter regression: fail");
    end
    $finish;
  end

endmodule
